FILE: hw/rtl/kfdp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Keyboard FIFO data port - shared definitions
// Opcodes, command and configuration structs, register indexes, ASCII codes.
// ---------------------------------------------------------------------------
package kfdp_pkg;

    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_TICK = 2'd1,
        OP_READ = 2'd2,
        OP_PRST = 2'd3
    } t_op;

    // classified item as held in the command queue
    typedef struct packed {
        t_op        op;
        logic [7:0] code;
    } t_cmd;

    typedef struct packed {
        logic force_upper;
        logic flag_invert;
        logic irq_enable;
    } t_cfg;

    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_FORCE_UPPER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLAG_INVERT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IRQ_ENABLE  = 2'd2;

    localparam logic [7:0] ASCII_LOWER_A = 8'h61;
    localparam logic [7:0] ASCII_LOWER_Z = 8'h7a;
    localparam logic [7:0] CASE_OFFSET   = 8'd32;

endpackage
`default_nettype wire

FILE: hw/rtl/kfdp_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Keyboard FIFO data port - front end
// Accepts items, classifies the opcode and holds them in a two-entry queue.
// ---------------------------------------------------------------------------
module kfdp_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_stall,
    input  wire logic [1:0]     i_opcode,
    input  wire logic [7:0]     i_key_code,
    output logic                o_cmd_valid,
    output kfdp_pkg::t_cmd      o_cmd,
    input  wire logic           i_cmd_pop
);

    kfdp_pkg::t_cmd r_q [2];
    logic           r_wr_idx;
    logic           r_rd_idx;
    logic [1:0]     r_count;
    logic [1:0]     n_count;
    logic           push;
    logic           pop;
    kfdp_pkg::t_cmd cmd_in;

    always_comb begin
        cmd_in.op   = kfdp_pkg::t_op'(i_opcode);
        // the code only matters to a push
        cmd_in.code = (cmd_in.op == kfdp_pkg::OP_PUSH) ? i_key_code : 8'd0;
    end

    assign o_stall     = (r_count == 2'd2);
    assign push        = i_valid && !o_stall;
    assign o_cmd_valid = (r_count != 2'd0);
    assign pop         = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_q[r_rd_idx];

    always_comb begin
        n_count = r_count;
        if (push && !pop) begin
            n_count = r_count + 2'd1;
        end else if (pop && !push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx <= 1'b0;
            r_rd_idx <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (push) begin
                r_wr_idx <= !r_wr_idx;
            end
            if (pop) begin
                r_rd_idx <= !r_rd_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_idx] <= cmd_in;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/kfdp_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Keyboard FIFO data port - back end
// Executes commands: key ring store, pointers, latch, interrupt and output.
// ---------------------------------------------------------------------------
module kfdp_back #(
    parameter int unsigned FIFO_DEPTH = 256
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  kfdp_pkg::t_cfg      i_cfg,
    input  wire logic           i_cmd_valid,
    input  kfdp_pkg::t_cmd      i_cmd,
    output logic                o_cmd_pop,
    output logic                o_valid,
    input  wire logic           i_stall,
    output logic [7:0]          o_data_value,
    output logic                o_flag_line,
    output logic                o_irq_line,
    output logic                o_key_dropped
);

    localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

    logic [7:0]       r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_rp, r_wp, n_rp, n_wp;
    logic             r_latch_empty, n_latch_empty;
    logic             r_irq, n_irq;
    logic [7:0]       r_latched_key;
    logic [7:0]       r_rd_data;

    logic             r_out_valid;
    logic             r_flag, r_drop, r_deliver, r_clear;

    logic             advance;
    logic [PTR_W-1:0] wp_next, rp_next;
    logic             fifo_full, fifo_empty;
    logic             do_write, deliver, clear, dropped;
    logic [7:0]       folded;

    assign wp_next    = (r_wp == PTR_LAST) ? '0 : r_wp + PTR_W'(1);
    assign rp_next    = (r_rp == PTR_LAST) ? '0 : r_rp + PTR_W'(1);
    assign fifo_full  = (wp_next == r_rp);
    assign fifo_empty = (r_rp == r_wp);

    assign advance   = i_cmd_valid && (!r_out_valid || !i_stall);
    assign o_cmd_pop = advance;

    always_comb begin
        n_rp          = r_rp;
        n_wp          = r_wp;
        n_latch_empty = r_latch_empty;
        n_irq         = r_irq;
        do_write      = 1'b0;
        deliver       = 1'b0;
        clear         = 1'b0;
        dropped       = 1'b0;
        case (i_cmd.op)
            kfdp_pkg::OP_PUSH: begin
                if (fifo_full) begin
                    dropped = 1'b1;
                end else begin
                    do_write = 1'b1;
                    n_wp     = wp_next;
                end
            end
            kfdp_pkg::OP_TICK: begin
                if (r_latch_empty && !fifo_empty) begin
                    deliver       = 1'b1;
                    n_rp          = rp_next;
                    n_latch_empty = 1'b0;
                    n_irq         = r_irq || i_cfg.irq_enable;
                end
            end
            kfdp_pkg::OP_READ: begin
                n_latch_empty = 1'b1;
                n_irq         = 1'b0;
            end
            kfdp_pkg::OP_PRST: begin
                n_latch_empty = 1'b1;
                clear         = 1'b1;
            end
            default: begin
                n_latch_empty = r_latch_empty;
            end
        endcase
    end

    // store write and registered read; a tick never reads the entry being written
    always_ff @(posedge i_clk) begin
        if (advance && do_write) begin
            r_mem[r_wp] <= i_cmd.code;
        end
        if (advance && deliver) begin
            r_rd_data <= r_mem[r_rp];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp          <= '0;
            r_wp          <= '0;
            r_latch_empty <= 1'b1;
            r_irq         <= 1'b0;
            r_out_valid   <= 1'b0;
            r_latched_key <= 8'd0;
        end else begin
            if (advance) begin
                r_rp          <= n_rp;
                r_wp          <= n_wp;
                r_latch_empty <= n_latch_empty;
                r_irq         <= n_irq;
                r_out_valid   <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid   <= 1'b0;
            end
            // latch content is settled once its item leaves
            if (r_out_valid && !i_stall) begin
                r_latched_key <= o_data_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_flag    <= n_latch_empty ^ i_cfg.flag_invert;
            r_drop    <= dropped;
            r_deliver <= deliver;
            r_clear   <= clear;
        end
    end

    assign folded = (i_cfg.force_upper && r_rd_data >= kfdp_pkg::ASCII_LOWER_A
                     && r_rd_data <= kfdp_pkg::ASCII_LOWER_Z)
                    ? r_rd_data - kfdp_pkg::CASE_OFFSET : r_rd_data;

    assign o_valid       = r_out_valid;
    assign o_data_value  = r_deliver ? folded : (r_clear ? 8'd0 : r_latched_key);
    assign o_flag_line   = r_flag;
    assign o_irq_line    = r_irq;
    assign o_key_dropped = r_drop;

`ifndef SYNTH
    a_push_full_keeps_wp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && dropped |=> $stable(r_wp))
        else $error("dropped push moved the write pointer");
    a_deliver_fills_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_deliver |-> !r_latch_empty)
        else $error("delivered item left the latch empty");
    a_clear_empties_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_clear |-> r_latch_empty && !r_deliver)
        else $error("port reset left the latch full");
    a_deliver_moves_rp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && deliver |=> r_rp != $past(r_rp))
        else $error("delivery did not advance the read pointer");
`endif

endmodule
`default_nettype wire

FILE: hw/rtl/keyboard_fifo_data_port_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Pipeline: an accepted item passes the queue stage, then the execute stage
// with registered store read, before its result reaches the outputs.
// Throughput: one item per cycle while i_stall is low, set by the single store access per item.
// Reset: synchronous, active low; pointers zero, latch empty, interrupt low,
// configuration zero. The key store has no reset and needs no clearing pass.
// ---------------------------------------------------------------------------
// Keyboard FIFO data port - top level
// Key code ring store behind a processor data port with ready flag and
// interrupt. Front end queues classified items, back end executes them.
// ---------------------------------------------------------------------------
module keyboard_fifo_data_port_unit #(
    parameter int unsigned FIFO_DEPTH = 256
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // configuration writes
    input  wire logic                              i_cfg_we,
    input  wire logic [kfdp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [kfdp_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // input items
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic [1:0]                        i_opcode,
    input  wire logic [7:0]                        i_key_code,
    // result items
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic [7:0]                             o_data_value,
    output logic                                   o_flag_line,
    output logic                                   o_irq_line,
    output logic                                   o_key_dropped
);

    // configuration registers; an index beyond the list is ignored
    kfdp_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                kfdp_pkg::CFG_FORCE_UPPER: r_cfg.force_upper <= i_cfg_data[0];
                kfdp_pkg::CFG_FLAG_INVERT: r_cfg.flag_invert <= i_cfg_data[0];
                kfdp_pkg::CFG_IRQ_ENABLE:  r_cfg.irq_enable  <= i_cfg_data[0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // front to back command path
    logic           cmd_valid;
    kfdp_pkg::t_cmd cmd;
    logic           cmd_pop;

    // front end: takes an item whenever its queue has room
    kfdp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_opcode    (i_opcode),
        .i_key_code  (i_key_code),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    // back end: runs one command per cycle while its output register is free
    kfdp_back #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_cmd_valid   (cmd_valid),
        .i_cmd         (cmd),
        .o_cmd_pop     (cmd_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_data_value  (o_data_value),
        .o_flag_line   (o_flag_line),
        .o_irq_line    (o_irq_line),
        .o_key_dropped (o_key_dropped)
    );

endmodule
`default_nettype wire
